[sv/bcr_pkg.sv]
// shared types and constants for the box collision resolver
// no dependencies; the other files that use it refer to it by scoped names
`timescale 1ns / 1ps

package bcr_pkg;

    // default internal coordinate width (signed, q16.16 at 32 bits)
    localparam int COORD_WIDTH_DEF = 32;

    // width of the coordinate fields at the ports
    localparam int PORT_WIDTH = 32;

    typedef enum logic [1:0] {
        ACT_LOAD     = 2'd0,
        ACT_RESOLVE  = 2'd1,
        ACT_CLASSIFY = 2'd2
    } t_action;

    // edge slots in the obstacle store and the edge arrays
    localparam logic [1:0] E_LEFT   = 2'd0;
    localparam logic [1:0] E_RIGHT  = 2'd1;
    localparam logic [1:0] E_TOP    = 2'd2;
    localparam logic [1:0] E_BOTTOM = 2'd3;

    // solid-side flag bits
    localparam logic [1:0] SOLID_SIDES  = 2'd0;
    localparam logic [1:0] SOLID_TOP    = 2'd1;
    localparam logic [1:0] SOLID_BOTTOM = 2'd2;

    // contact mask bits
    localparam logic [1:0] CT_LEFT   = 2'd0;
    localparam logic [1:0] CT_RIGHT  = 2'd1;
    localparam logic [1:0] CT_TOP    = 2'd2;
    localparam logic [1:0] CT_BOTTOM = 2'd3;

    typedef struct packed {
        logic [3:0] mask;
        logic       zero_x;
        logic       zero_y;
    } t_contact;

endpackage

[sv/bcr_front.sv]
// input register: captures one transaction and clamps coordinates to the internal range
// depends on bcr_pkg
`timescale 1ns / 1ps

module bcr_front #(
    parameter int W = bcr_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_drain,
    input  logic [1:0]             i_action,
    input  logic signed [31:0]     i_cur [4],
    input  logic signed [31:0]     i_prev [4],
    input  logic [2:0]             i_solid,
    output logic                   o_valid,
    output bcr_pkg::t_action       o_action,
    output logic signed [W-1:0]    o_cur [4],
    output logic signed [W-1:0]    o_prev [4],
    output logic [2:0]             o_solid
);

    localparam int XW = (W > bcr_pkg::PORT_WIDTH) ? W : bcr_pkg::PORT_WIDTH;
    localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic                r_valid;
    bcr_pkg::t_action    r_action;
    logic signed [W-1:0] r_cur [4];
    logic signed [W-1:0] r_prev [4];
    logic [2:0]          r_solid;
    logic                n_valid;
    logic                act_known;

    function automatic logic signed [W-1:0] take(input logic signed [31:0] raw);
        logic signed [XW-1:0] ext;
        ext = XW'(raw);
        if (ext > SAT_HI) begin
            take = SAT_HI[W-1:0];
        end else if (ext < SAT_LO) begin
            take = SAT_LO[W-1:0];
        end else begin
            take = ext[W-1:0];
        end
    endfunction

    // the undefined action code is dropped here and never enters the pipe
    always_comb begin
        case (i_action) inside
            bcr_pkg::ACT_LOAD, bcr_pkg::ACT_RESOLVE, bcr_pkg::ACT_CLASSIFY: act_known = 1'b1;
            default: act_known = 1'b0;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (i_accept) begin
            n_valid = act_known;
        end else if (i_drain) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_action <= bcr_pkg::t_action'(i_action);
            r_solid  <= i_solid;
            for (int k = 0; k < 4; k++) begin
                r_cur[k]  <= take(i_cur[k]);
                r_prev[k] <= take(i_prev[k]);
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_action = r_action;
    assign o_cur    = r_cur;
    assign o_prev   = r_prev;
    assign o_solid  = r_solid;

endmodule

[sv/bcr_core.sv]
// obstacle store and the single-pass classify / push-out logic
// depends on bcr_pkg
`timescale 1ns / 1ps

module bcr_core #(
    parameter int W = bcr_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  bcr_pkg::t_action       i_action,
    input  logic signed [W-1:0]    i_cur [4],
    input  logic signed [W-1:0]    i_prev [4],
    input  logic [2:0]             i_solid,
    output logic                   o_has_result,
    output logic signed [W-1:0]    o_edge [4],
    output bcr_pkg::t_contact      o_contact
);

    localparam int DW = W + 2;
    localparam logic signed [DW-1:0] SAT_HI = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_LO = {3'b111, {(W-1){1'b0}}};

    logic signed [W-1:0] r_obs [4];
    logic [2:0]          r_obs_solid;

    logic signed [W-1:0] cl, cr, ct, cb, pl, pr, pt, pb, fl, fr, ft, fb;
    logic signed [DW-1:0] d_l, d_r, d_t, d_b;
    logic signed [W-1:0] l1, r1, l2, r2, t1, b1, t2, b2;
    logic up_col, bot_col, vin, vout, l_col, r_col, hin, hout;
    logic x_top, x_bot, x_left, x_right, vert, horz;
    logic push_l, push_r, push_t, push_b;
    logic cu_col, cb_col, cl_col, cr_col, c_vert, c_horz;

    function automatic logic signed [W-1:0] sat(input logic signed [DW-1:0] v);
        if (v > SAT_HI) begin
            sat = SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            sat = SAT_LO[W-1:0];
        end else begin
            sat = v[W-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_obs[k] <= '0;
            end
            r_obs_solid <= '0;
        end else if (i_valid && i_action == bcr_pkg::ACT_LOAD) begin
            r_obs       <= i_cur;
            r_obs_solid <= i_solid;
        end
    end

    assign cl = i_cur[bcr_pkg::E_LEFT];
    assign cr = i_cur[bcr_pkg::E_RIGHT];
    assign ct = i_cur[bcr_pkg::E_TOP];
    assign cb = i_cur[bcr_pkg::E_BOTTOM];
    assign pl = i_prev[bcr_pkg::E_LEFT];
    assign pr = i_prev[bcr_pkg::E_RIGHT];
    assign pt = i_prev[bcr_pkg::E_TOP];
    assign pb = i_prev[bcr_pkg::E_BOTTOM];
    assign fl = r_obs[bcr_pkg::E_LEFT];
    assign fr = r_obs[bcr_pkg::E_RIGHT];
    assign ft = r_obs[bcr_pkg::E_TOP];
    assign fb = r_obs[bcr_pkg::E_BOTTOM];

    // resolve overlap classes (edge contact counts)
    assign up_col  = (ct > ft) && (cb <= ft);
    assign bot_col = (cb < fb) && (ct >= fb);
    assign vin     = (ct <= ft) && (cb >= fb);
    assign vout    = (ct >= ft) && (cb <= fb);
    assign l_col   = (cl < fl) && (cr >= fl);
    assign r_col   = (cr > fr) && (cl <= fr);
    assign hin     = (cl >= fl) && (cr <= fr);
    assign hout    = (cl <= fl) && (cr >= fr);
    assign vert    = up_col || bot_col || vin || vout;
    assign horz    = l_col || r_col || hin || hout;

    // crossings against the box before the move
    assign x_top   = (pb >= ft) && (cb < ft);
    assign x_bot   = (pt <= fb) && (ct > fb);
    assign x_left  = (pr <= fl) && (cr > fl);
    assign x_right = (pl >= fr) && (cl < fr);

    assign push_l = r_obs_solid[bcr_pkg::SOLID_SIDES] && vert && x_left;
    assign push_r = r_obs_solid[bcr_pkg::SOLID_SIDES] && vert && x_right;
    assign push_t = r_obs_solid[bcr_pkg::SOLID_TOP] && horz && x_top;
    assign push_b = r_obs_solid[bcr_pkg::SOLID_BOTTOM] && horz && x_bot;

    // each push starts from the edges the previous one left
    always_comb begin
        d_l = DW'(cr) - DW'(fl);
        l1  = push_l ? sat(DW'(cl) - d_l) : cl;
        r1  = push_l ? sat(DW'(cr) - d_l) : cr;
        d_r = DW'(fr) - DW'(l1);
        l2  = push_r ? sat(DW'(l1) + d_r) : l1;
        r2  = push_r ? sat(DW'(r1) + d_r) : r1;
        d_t = DW'(ft) - DW'(cb);
        t1  = push_t ? sat(DW'(ct) + d_t) : ct;
        b1  = push_t ? sat(DW'(cb) + d_t) : cb;
        d_b = DW'(t1) - DW'(fb);
        t2  = push_b ? sat(DW'(t1) - d_b) : t1;
        b2  = push_b ? sat(DW'(b1) - d_b) : b1;
    end

    // classify uses strict overlap on the edge tests
    assign cu_col = (ct > ft) && (cb < ft);
    assign cb_col = (cb < fb) && (ct > fb);
    assign cl_col = (cl < fl) && (cr > fl);
    assign cr_col = (cr > fr) && (cl < fr);
    assign c_vert = cu_col || cb_col || vin || vout;
    assign c_horz = cl_col || cr_col || hin || hout;

    always_comb begin
        o_has_result = 1'b0;
        o_edge       = i_cur;
        o_contact    = '0;
        unique case (i_action)
            bcr_pkg::ACT_RESOLVE: begin
                o_has_result                        = 1'b1;
                o_edge[bcr_pkg::E_LEFT]             = l2;
                o_edge[bcr_pkg::E_RIGHT]            = r2;
                o_edge[bcr_pkg::E_TOP]              = t2;
                o_edge[bcr_pkg::E_BOTTOM]           = b2;
                o_contact.mask[bcr_pkg::CT_LEFT]    = push_l;
                o_contact.mask[bcr_pkg::CT_RIGHT]   = push_r;
                o_contact.mask[bcr_pkg::CT_TOP]     = push_t;
                o_contact.mask[bcr_pkg::CT_BOTTOM]  = push_b;
                o_contact.zero_x                    = push_l || push_r;
                o_contact.zero_y                    = push_t || push_b;
            end
            bcr_pkg::ACT_CLASSIFY: begin
                o_has_result                        = 1'b1;
                o_contact.mask[bcr_pkg::CT_LEFT]    = c_vert && cl_col;
                o_contact.mask[bcr_pkg::CT_RIGHT]   = c_vert && cr_col;
                o_contact.mask[bcr_pkg::CT_TOP]     = c_horz && cu_col;
                o_contact.mask[bcr_pkg::CT_BOTTOM]  = c_horz && cb_col;
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

endmodule

[sv/bcr_back.sv]
// result register: holds one result transaction until the receiver takes it
// depends on bcr_pkg
`timescale 1ns / 1ps

module bcr_back #(
    parameter int W = bcr_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_take,
    input  logic signed [W-1:0]    i_edge [4],
    input  bcr_pkg::t_contact      i_contact,
    output logic                   o_valid,
    output logic signed [31:0]     o_edge [4],
    output bcr_pkg::t_contact      o_contact
);

    localparam int XW = (W > bcr_pkg::PORT_WIDTH) ? W : bcr_pkg::PORT_WIDTH;

    logic                 r_valid;
    logic                 n_valid;
    logic signed [31:0]   r_edge [4];
    bcr_pkg::t_contact    r_contact;
    logic signed [XW-1:0] wide [4];

    // ports carry the low 32 bits, sign-extended first when narrower
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            wide[k] = XW'(i_edge[k]);
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_contact <= i_contact;
            for (int k = 0; k < 4; k++) begin
                r_edge[k] <= wide[k][31:0];
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_edge    = r_edge;
    assign o_contact = r_contact;

endmodule

[sv/box_collision_resolver_top.sv]
// box collision resolver: one moving box against one stored obstacle box
// channels: input transaction (i_in_valid / o_in_stall) carries action, current and
// previous edges and solid flags; output transaction (o_out_valid / i_out_stall)
// carries pushed edges, contact mask and velocity-clear flags
// a load stores the obstacle and gives no output; resolve and classify each give one
// the input register loads at the accepting edge; the result register takes each
// result after one pass of compare / push logic, once it is free or being emptied
// throughput: one transaction per cycle unless the receiver stalls, set by the
// single pass between the two registers; a load followed by a resolve in the next
// cycle sees the new obstacle
// when the receiver stalls the result stays in the result register, one more
// transaction is held in the input register, and only then does o_in_stall rise
// reset (synchronous, active low) empties both registers and clears the obstacle
// to all-zero edges with no solid sides
// depends on bcr_pkg, bcr_front, bcr_core, bcr_back
`timescale 1ns / 1ps

module box_collision_resolver_top #(
    parameter int COORD_WIDTH = bcr_pkg::COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_cur_left,
    input  logic signed [31:0] i_cur_right,
    input  logic signed [31:0] i_cur_top,
    input  logic signed [31:0] i_cur_bottom,
    input  logic signed [31:0] i_prev_left,
    input  logic signed [31:0] i_prev_right,
    input  logic signed [31:0] i_prev_top,
    input  logic signed [31:0] i_prev_bottom,
    input  logic [2:0]         i_solid_sides,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_new_left,
    output logic signed [31:0] o_new_right,
    output logic signed [31:0] o_new_top,
    output logic signed [31:0] o_new_bottom,
    output logic [3:0]         o_contact_mask,
    output logic               o_zero_vel_x,
    output logic               o_zero_vel_y
);

    logic signed [31:0]            cur_raw [4];
    logic signed [31:0]            prev_raw [4];
    logic                          in_accept;
    logic                          s1_valid;
    logic                          s1_move;
    logic                          out_ready;
    bcr_pkg::t_action              s1_action;
    logic signed [COORD_WIDTH-1:0] s1_cur [4];
    logic signed [COORD_WIDTH-1:0] s1_prev [4];
    logic [2:0]                    s1_solid;
    logic                          has_result;
    logic signed [COORD_WIDTH-1:0] res_edge [4];
    bcr_pkg::t_contact             res_contact;
    logic signed [31:0]            out_edge [4];
    bcr_pkg::t_contact             out_contact;

    assign cur_raw[bcr_pkg::E_LEFT]    = i_cur_left;
    assign cur_raw[bcr_pkg::E_RIGHT]   = i_cur_right;
    assign cur_raw[bcr_pkg::E_TOP]     = i_cur_top;
    assign cur_raw[bcr_pkg::E_BOTTOM]  = i_cur_bottom;
    assign prev_raw[bcr_pkg::E_LEFT]   = i_prev_left;
    assign prev_raw[bcr_pkg::E_RIGHT]  = i_prev_right;
    assign prev_raw[bcr_pkg::E_TOP]    = i_prev_top;
    assign prev_raw[bcr_pkg::E_BOTTOM] = i_prev_bottom;

    // loads leave the input register without needing the result register
    assign out_ready  = !o_out_valid || !i_out_stall;
    assign s1_move    = s1_valid && (!has_result || out_ready);
    assign o_in_stall = s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    bcr_front #(
        .W (COORD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_drain  (s1_move),
        .i_action (i_action),
        .i_cur    (cur_raw),
        .i_prev   (prev_raw),
        .i_solid  (i_solid_sides),
        .o_valid  (s1_valid),
        .o_action (s1_action),
        .o_cur    (s1_cur),
        .o_prev   (s1_prev),
        .o_solid  (s1_solid)
    );

    bcr_core #(
        .W (COORD_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s1_valid),
        .i_action     (s1_action),
        .i_cur        (s1_cur),
        .i_prev       (s1_prev),
        .i_solid      (s1_solid),
        .o_has_result (has_result),
        .o_edge       (res_edge),
        .o_contact    (res_contact)
    );

    bcr_back #(
        .W (COORD_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (s1_valid && has_result && out_ready),
        .i_take    (!i_out_stall),
        .i_edge    (res_edge),
        .i_contact (res_contact),
        .o_valid   (o_out_valid),
        .o_edge    (out_edge),
        .o_contact (out_contact)
    );

    assign o_new_left     = out_edge[bcr_pkg::E_LEFT];
    assign o_new_right    = out_edge[bcr_pkg::E_RIGHT];
    assign o_new_top      = out_edge[bcr_pkg::E_TOP];
    assign o_new_bottom   = out_edge[bcr_pkg::E_BOTTOM];
    assign o_contact_mask = out_contact.mask;
    assign o_zero_vel_x   = out_contact.zero_x;
    assign o_zero_vel_y   = out_contact.zero_y;

endmodule

[sv/bcr_checker.sv]
// port-level checks for the box collision resolver, bound to the top level
// depends on box_collision_resolver_top's port list
`timescale 1ns / 1ps

module bcr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_new_left,
    input logic signed [31:0] o_new_right,
    input logic signed [31:0] o_new_top,
    input logic signed [31:0] o_new_bottom,
    input logic [3:0]         o_contact_mask,
    input logic               o_zero_vel_x,
    input logic               o_zero_vel_y
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_new_left) && $stable(o_new_right)
            && $stable(o_new_top) && $stable(o_new_bottom) && $stable(o_contact_mask))
        else $error("stalled result changed");

    // a horizontal velocity clear comes only with a side contact
    a_zero_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_vel_x |-> o_contact_mask[1:0] != 2'b00)
        else $error("zero_vel_x without side contact");

    // a vertical velocity clear comes only with a top or bottom contact
    a_zero_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_vel_y |-> o_contact_mask[3:2] != 2'b00)
        else $error("zero_vel_y without top or bottom contact");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind box_collision_resolver_top bcr_checker u_bcr_checker (.*);

[verif/testbench.sv]
// self-checking testbench for box_collision_resolver_top: directed and random transactions
// are predicted in the bench and every output transaction is compared with the oldest one
// depends on bcr_pkg and the rtl of box_collision_resolver_top
`timescale 1ns / 1ps

module testbench;

    localparam int CW = bcr_pkg::COORD_WIDTH_DEF;
    localparam logic [1:0] ACT_LOAD      = bcr_pkg::ACT_LOAD;
    localparam logic [1:0] ACT_RESOLVE   = bcr_pkg::ACT_RESOLVE;
    localparam logic [1:0] ACT_CLASSIFY  = bcr_pkg::ACT_CLASSIFY;
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;
    localparam logic [1:0] E_LEFT        = bcr_pkg::E_LEFT;
    localparam logic [1:0] E_RIGHT       = bcr_pkg::E_RIGHT;
    localparam logic [1:0] E_TOP         = bcr_pkg::E_TOP;
    localparam logic [1:0] E_BOTTOM      = bcr_pkg::E_BOTTOM;
    localparam logic [1:0] SOLID_SIDES   = bcr_pkg::SOLID_SIDES;
    localparam logic [1:0] SOLID_TOP     = bcr_pkg::SOLID_TOP;
    localparam logic [1:0] SOLID_BOTTOM  = bcr_pkg::SOLID_BOTTOM;
    localparam logic [1:0] CT_LEFT       = bcr_pkg::CT_LEFT;
    localparam logic [1:0] CT_RIGHT      = bcr_pkg::CT_RIGHT;
    localparam logic [1:0] CT_TOP        = bcr_pkg::CT_TOP;
    localparam logic [1:0] CT_BOTTOM     = bcr_pkg::CT_BOTTOM;
    localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] CMIN = 32'h8000_0000;
    localparam int TAIL_CYCLES = 8;
    localparam int CALM_ITEMS = 150;
    localparam int RANDOM_ITEMS = 1300;

    typedef struct packed {
        logic [1:0]       action;
        logic [3:0][31:0] cur;
        logic [3:0][31:0] prv;
        logic [2:0]       solid;
    } t_box_item;

    typedef struct packed {
        logic [3:0][31:0]  edges;
        bcr_pkg::t_contact contact;
    } t_box_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_action;
    logic [31:0] i_cur_left, i_cur_right, i_cur_top, i_cur_bottom;
    logic [31:0] i_prev_left, i_prev_right, i_prev_top, i_prev_bottom;
    logic [2:0]  i_solid_sides;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_new_left, o_new_right, o_new_top, o_new_bottom;
    logic [3:0]  o_contact_mask;
    logic        o_zero_vel_x, o_zero_vel_y;

    // predictor copy of the obstacle
    longint      obst_edge [4];
    logic [2:0]  obst_solid;

    t_box_result expected_boxes [$];
    int          err_count = 0;
    bit          send_idle_en = 1'b1;
    bit          recv_idle_en = 1'b1;
    int          stall_left = 0;

    // obstacle used to shape well-formed random movers, in whole units around a base
    int          g_l, g_r, g_b, g_t;
    longint      g_base = 0;

    box_collision_resolver_top #(.COORD_WIDTH(CW)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_cur_left     (i_cur_left),
        .i_cur_right    (i_cur_right),
        .i_cur_top      (i_cur_top),
        .i_cur_bottom   (i_cur_bottom),
        .i_prev_left    (i_prev_left),
        .i_prev_right   (i_prev_right),
        .i_prev_top     (i_prev_top),
        .i_prev_bottom  (i_prev_bottom),
        .i_solid_sides  (i_solid_sides),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_new_left     (o_new_left),
        .o_new_right    (o_new_right),
        .o_new_top      (o_new_top),
        .o_new_bottom   (o_new_bottom),
        .o_contact_mask (o_contact_mask),
        .o_zero_vel_x   (o_zero_vel_x),
        .o_zero_vel_y   (o_zero_vel_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint clamp_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // returns 1 when the transaction produces an output transaction
    function automatic bit predict_push(input t_box_item it, output t_box_result r);
        longint c [4];
        longint p [4];
        longint fl, fr, ft, fb, d;
        logic   up_col, bot_col, vin, vout, l_col, r_col, hin, hout;
        logic   x_top, x_bot, x_left, x_right, vert, horz;
        int     i;
        r = '0;
        for (i = 0; i < 4; i++) begin
            c[i] = clamp_coord(longint'($signed(it.cur[i])));
            p[i] = clamp_coord(longint'($signed(it.prv[i])));
        end
        fl = obst_edge[E_LEFT];
        fr = obst_edge[E_RIGHT];
        ft = obst_edge[E_TOP];
        fb = obst_edge[E_BOTTOM];
        case (it.action)
            ACT_LOAD: begin
                for (i = 0; i < 4; i++) obst_edge[i] = c[i];
                obst_solid = it.solid;
                return 1'b0;
            end
            ACT_RESOLVE: begin
                up_col  = c[E_TOP] > ft && c[E_BOTTOM] <= ft;
                bot_col = c[E_BOTTOM] < fb && c[E_TOP] >= fb;
                vin     = c[E_TOP] <= ft && c[E_BOTTOM] >= fb;
                vout    = c[E_TOP] >= ft && c[E_BOTTOM] <= fb;
                l_col   = c[E_LEFT] < fl && c[E_RIGHT] >= fl;
                r_col   = c[E_RIGHT] > fr && c[E_LEFT] <= fr;
                hin     = c[E_LEFT] >= fl && c[E_RIGHT] <= fr;
                hout    = c[E_LEFT] <= fl && c[E_RIGHT] >= fr;
                // crossings judged on the edges as they came in
                x_top   = p[E_BOTTOM] >= ft && c[E_BOTTOM] < ft;
                x_bot   = p[E_TOP] <= fb && c[E_TOP] > fb;
                x_left  = p[E_RIGHT] <= fl && c[E_RIGHT] > fl;
                x_right = p[E_LEFT] >= fr && c[E_LEFT] < fr;
                vert = up_col || bot_col || vin || vout;
                horz = l_col || r_col || hin || hout;
                if (obst_solid[SOLID_SIDES] && vert) begin
                    if (x_left) begin
                        d = c[E_RIGHT] - fl;
                        c[E_LEFT] = clamp_coord(c[E_LEFT] - d);
                        c[E_RIGHT] = clamp_coord(c[E_RIGHT] - d);
                        r.contact.zero_x = 1'b1;
                        r.contact.mask[CT_LEFT] = 1'b1;
                    end
                    if (x_right) begin
                        d = fr - c[E_LEFT];
                        c[E_LEFT] = clamp_coord(c[E_LEFT] + d);
                        c[E_RIGHT] = clamp_coord(c[E_RIGHT] + d);
                        r.contact.zero_x = 1'b1;
                        r.contact.mask[CT_RIGHT] = 1'b1;
                    end
                end
                if (horz) begin
                    if (obst_solid[SOLID_TOP] && x_top) begin
                        d = ft - c[E_BOTTOM];
                        c[E_TOP] = clamp_coord(c[E_TOP] + d);
                        c[E_BOTTOM] = clamp_coord(c[E_BOTTOM] + d);
                        r.contact.zero_y = 1'b1;
                        r.contact.mask[CT_TOP] = 1'b1;
                    end
                    if (obst_solid[SOLID_BOTTOM] && x_bot) begin
                        d = c[E_TOP] - fb;
                        c[E_TOP] = clamp_coord(c[E_TOP] - d);
                        c[E_BOTTOM] = clamp_coord(c[E_BOTTOM] - d);
                        r.contact.zero_y = 1'b1;
                        r.contact.mask[CT_BOTTOM] = 1'b1;
                    end
                end
            end
            ACT_CLASSIFY: begin
                // strict overlap on the edge tests
                up_col  = c[E_TOP] > ft && c[E_BOTTOM] < ft;
                bot_col = c[E_BOTTOM] < fb && c[E_TOP] > fb;
                vin     = c[E_TOP] <= ft && c[E_BOTTOM] >= fb;
                vout    = c[E_TOP] >= ft && c[E_BOTTOM] <= fb;
                l_col   = c[E_LEFT] < fl && c[E_RIGHT] > fl;
                r_col   = c[E_RIGHT] > fr && c[E_LEFT] < fr;
                hin     = c[E_LEFT] >= fl && c[E_RIGHT] <= fr;
                hout    = c[E_LEFT] <= fl && c[E_RIGHT] >= fr;
                vert = up_col || bot_col || vin || vout;
                horz = l_col || r_col || hin || hout;
                r.contact.mask[CT_LEFT]   = vert && l_col;
                r.contact.mask[CT_RIGHT]  = vert && r_col;
                r.contact.mask[CT_TOP]    = horz && up_col;
                r.contact.mask[CT_BOTTOM] = horz && bot_col;
            end
            default: return 1'b0;
        endcase
        for (i = 0; i < 4; i++) r.edges[i] = c[i][31:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic send_item(input t_box_item it);
        t_box_result want;
        if (send_idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= it.action;
        i_cur_left    <= it.cur[E_LEFT];
        i_cur_right   <= it.cur[E_RIGHT];
        i_cur_top     <= it.cur[E_TOP];
        i_cur_bottom  <= it.cur[E_BOTTOM];
        i_prev_left   <= it.prv[E_LEFT];
        i_prev_right  <= it.prv[E_RIGHT];
        i_prev_top    <= it.prv[E_TOP];
        i_prev_bottom <= it.prv[E_BOTTOM];
        i_solid_sides <= it.solid;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_push(it, want)) expected_boxes.push_back(want);
    endtask

    // random receiver stall bursts, off while recv_idle_en is clear
    always @(posedge i_clk) begin
        if (!i_rst_n || !recv_idle_en) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 7);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_box_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_boxes.size() == 0) begin
                report_mismatch("output transaction with nothing pending", o_new_left, '0);
            end else begin
                want = expected_boxes.pop_front();
                if (o_new_left !== want.edges[E_LEFT])
                    report_mismatch("new_left", o_new_left, want.edges[E_LEFT]);
                if (o_new_right !== want.edges[E_RIGHT])
                    report_mismatch("new_right", o_new_right, want.edges[E_RIGHT]);
                if (o_new_top !== want.edges[E_TOP])
                    report_mismatch("new_top", o_new_top, want.edges[E_TOP]);
                if (o_new_bottom !== want.edges[E_BOTTOM])
                    report_mismatch("new_bottom", o_new_bottom, want.edges[E_BOTTOM]);
                if (o_contact_mask !== want.contact.mask)
                    report_mismatch("contact_mask", 32'(o_contact_mask), 32'(want.contact.mask));
                if (o_zero_vel_x !== want.contact.zero_x)
                    report_mismatch("zero_vel_x", 32'(o_zero_vel_x), 32'(want.contact.zero_x));
                if (o_zero_vel_y !== want.contact.zero_y)
                    report_mismatch("zero_vel_y", 32'(o_zero_vel_y), 32'(want.contact.zero_y));
            end
        end
    end

    function automatic logic [31:0] q16(input int units);
        return units <<< 16;
    endfunction

    function automatic t_box_item mk_box(input logic [1:0] act,
                                         input logic [31:0] cl, cr, ct, cb, pl, pr, pt, pb,
                                         input logic [2:0] solid);
        t_box_item it;
        it.action       = act;
        it.cur[E_LEFT]  = cl;
        it.cur[E_RIGHT] = cr;
        it.cur[E_TOP]   = ct;
        it.cur[E_BOTTOM] = cb;
        it.prv[E_LEFT]  = pl;
        it.prv[E_RIGHT] = pr;
        it.prv[E_TOP]   = pt;
        it.prv[E_BOTTOM] = pb;
        it.solid        = solid;
        return it;
    endfunction

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // grid point around the current base, now and then off the grid
    function automatic logic [31:0] q_at(input int units);
        longint v;
        v = g_base + (longint'(units) <<< 16);
        if ($urandom_range(0, 5) == 0) v = v + longint'($urandom_range(0, 65535));
        v = clamp_coord(v);
        return v[31:0];
    endfunction

    function automatic t_box_item random_obstacle();
        t_box_item it;
        case ($urandom_range(0, 7))
            0:       g_base = longint'(CMAX) - (longint'(4) <<< 16);
            1:       g_base = (longint'(4) <<< 16) - longint'(CMAX);
            default: g_base = 0;
        endcase
        g_l = rand_between(-6, 2);
        g_r = g_l + rand_between(1, 6);
        g_b = rand_between(-6, 2);
        g_t = g_b + rand_between(1, 6);
        it.action        = ACT_LOAD;
        it.cur[E_LEFT]   = q_at(g_l);
        it.cur[E_RIGHT]  = q_at(g_r);
        it.cur[E_TOP]    = q_at(g_t);
        it.cur[E_BOTTOM] = q_at(g_b);
        it.prv           = {$urandom, $urandom, $urandom, $urandom};
        it.solid         = 3'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic t_box_item random_mover(input logic [1:0] act);
        t_box_item it;
        int ml, mb, w, h, dx, dy;
        ml = rand_between(g_l - 5, g_r + 1);
        mb = rand_between(g_b - 5, g_t + 1);
        w  = rand_between(1, 4);
        h  = rand_between(1, 4);
        if ($urandom_range(0, 19) == 0) w = -w;
        if ($urandom_range(0, 19) == 0) h = -h;
        dx = rand_between(-3, 3);
        dy = rand_between(-3, 3);
        it.action        = act;
        it.cur[E_LEFT]   = q_at(ml);
        it.cur[E_RIGHT]  = q_at(ml + w);
        it.cur[E_TOP]    = q_at(mb + h);
        it.cur[E_BOTTOM] = q_at(mb);
        it.prv[E_LEFT]   = q_at(ml - dx);
        it.prv[E_RIGHT]  = q_at(ml + w - dx);
        it.prv[E_TOP]    = q_at(mb + h - dy);
        it.prv[E_BOTTOM] = q_at(mb - dy);
        it.solid         = 3'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic t_box_item random_noise(input logic [1:0] act);
        t_box_item it;
        it.action = act;
        it.cur    = {$urandom, $urandom, $urandom, $urandom};
        it.prv    = {$urandom, $urandom, $urandom, $urandom};
        it.solid  = 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic test_reset_obstacle();
        send_item(mk_box(ACT_CLASSIFY, q16(-1), q16(1), q16(1), q16(-1), 0, 0, 0, 0, 3'b000));
        send_item(mk_box(ACT_RESOLVE, q16(-1), q16(1), q16(1), q16(-1),
                         q16(-3), q16(-1), q16(3), q16(1), 3'b111));
    endtask

    task automatic test_strict_contacts();
        send_item(mk_box(ACT_LOAD, 0, q16(4), q16(4), 0, 0, 0, 0, 0, 3'b000));
        send_item(mk_box(ACT_CLASSIFY, q16(-2), q16(1), q16(3), q16(1), 0, 0, 0, 0, 3'b000));
        send_item(mk_box(ACT_CLASSIFY, q16(3), q16(6), q16(3), q16(1), 0, 0, 0, 0, 3'b000));
        send_item(mk_box(ACT_CLASSIFY, q16(1), q16(3), q16(5), q16(3), 0, 0, 0, 0, 3'b000));
        send_item(mk_box(ACT_CLASSIFY, q16(1), q16(3), q16(1), q16(-1), 0, 0, 0, 0, 3'b000));
        // edges touching only: no strict overlap
        send_item(mk_box(ACT_CLASSIFY, q16(-2), 0, q16(3), q16(1), 0, 0, 0, 0, 3'b000));
        send_item(mk_box(ACT_CLASSIFY, q16(10), q16(12), q16(20), q16(18), 0, 0, 0, 0, 3'b000));
    endtask

    task automatic test_side_push();
        send_item(mk_box(ACT_LOAD, 0, q16(4), q16(4), 0, 0, 0, 0, 0, 3'b001));
        send_item(mk_box(ACT_RESOLVE, q16(-2), q16(1), q16(3), q16(1),
                         q16(-3), q16(-1), q16(3), q16(1), 3'b000));
        send_item(mk_box(ACT_RESOLVE, q16(3), q16(5), q16(3), q16(1),
                         q16(5), q16(7), q16(3), q16(1), 3'b000));
    endtask

    task automatic test_top_bottom_push();
        send_item(mk_box(ACT_LOAD, 0, q16(4), q16(4), 0, 0, 0, 0, 0, 3'b110));
        send_item(mk_box(ACT_RESOLVE, q16(1), q16(2), q16(5), q16(3),
                         q16(1), q16(2), q16(6), q16(4), 3'b000));
        send_item(mk_box(ACT_RESOLVE, q16(1), q16(2), q16(1), q16(-1),
                         q16(1), q16(2), 0, q16(-2), 3'b000));
    endtask

    // side and top crossed in one move: pushes stack
    task automatic test_corner_push();
        send_item(mk_box(ACT_LOAD, 0, q16(4), q16(4), 0, 0, 0, 0, 0, 3'b111));
        send_item(mk_box(ACT_RESOLVE, q16(-1), q16(1), q16(5), q16(3),
                         q16(-3), q16(-1), q16(7), q16(5), 3'b000));
    endtask

    task automatic test_saturation();
        send_item(mk_box(ACT_LOAD, CMIN, CMAX, 0, 0, 0, 0, 0, 0, 3'b111));
        send_item(mk_box(ACT_RESOLVE, 0, CMAX, q16(1), q16(-1), CMAX, CMIN, 0, 0, 3'b000));
        send_item(mk_box(ACT_LOAD, 0, q16(4), CMAX, CMAX - q16(1), 0, 0, 0, 0, 3'b010));
        send_item(mk_box(ACT_RESOLVE, q16(1), q16(2), CMAX, CMAX - q16(2),
                         q16(1), q16(2), CMAX, CMAX, 3'b000));
    endtask

    task automatic test_undefined_action();
        send_item(mk_box(ACT_UNDEFINED, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, 3'b111));
        send_item(mk_box(ACT_CLASSIFY, q16(1), q16(3), q16(3), q16(1), 0, 0, 0, 0, 3'b000));
    endtask

    task automatic test_inverted_boxes();
        send_item(mk_box(ACT_LOAD, q16(4), 0, 0, q16(4), 0, 0, 0, 0, 3'b111));
        send_item(mk_box(ACT_RESOLVE, q16(3), q16(1), q16(1), q16(3),
                         q16(5), q16(-1), q16(-1), q16(5), 3'b000));
        send_item(mk_box(ACT_CLASSIFY, q16(3), q16(1), q16(1), q16(3), 0, 0, 0, 0, 3'b000));
    endtask

    task automatic test_field_extremes();
        send_item(mk_box(ACT_LOAD, '1, '1, '1, '1, '1, '1, '1, '1, 3'b111));
        send_item(mk_box(ACT_RESOLVE, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, 3'b111));
        send_item(mk_box(ACT_CLASSIFY, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 3'b000));
    endtask

    task automatic test_random_traffic(input int n_items);
        int done;
        int pick;
        done = 0;
        send_item(random_obstacle());
        while (done < n_items) begin
            if (done >= n_items - CALM_ITEMS) begin
                send_idle_en = 1'b0;
                recv_idle_en = 1'b0;
            end else if (done % 100 == 0) begin
                send_idle_en = ($urandom_range(0, 3) != 0);
                recv_idle_en = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                // ignored transaction, not counted
                send_item(random_noise(ACT_UNDEFINED));
            end else begin
                if (pick < 9)
                    send_item(random_obstacle());
                else if (pick < 62)
                    send_item(random_mover(ACT_RESOLVE));
                else if (pick < 86)
                    send_item(random_mover(ACT_CLASSIFY));
                else
                    send_item(random_noise(2'($urandom_range(0, 2))));
                done++;
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_LOAD;
        i_cur_left    <= '0;
        i_cur_right   <= '0;
        i_cur_top     <= '0;
        i_cur_bottom  <= '0;
        i_prev_left   <= '0;
        i_prev_right  <= '0;
        i_prev_top    <= '0;
        i_prev_bottom <= '0;
        i_solid_sides <= '0;
        obst_edge     = '{default: 0};
        obst_solid    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_obstacle();
        test_strict_contacts();
        test_side_push();
        test_top_bottom_push();
        test_corner_push();
        test_saturation();
        test_undefined_action();
        test_inverted_boxes();
        test_field_extremes();
        test_random_traffic(RANDOM_ITEMS);

        i_in_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_boxes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
